// ===== design/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// trq_pkg
// Shared types for the timed reply queue: the scan record that walks the
// chain of slot cells, and its operation codes.
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    typedef enum logic [1:0] {
        REC_IDLE   = 2'd0,
        REC_INSERT = 2'd1,
        REC_POLL   = 2'd2
    } trq_op_t;

    // time_val is the due time of an insert, or the current time of a poll.
    // For a poll the payload fields hold the best candidate so far.
    typedef struct packed {
        logic        valid;
        trq_op_t     op;
        logic        hit;
        logic [31:0] time_val;
        logic [31:0] best_due;
        logic [7:0]  module_id;
        logic [3:0]  kind_code;
        logic [31:0] argument;
    } trq_rec_t;

endpackage

// ===== design/trq_req_if.sv =====
// ----------------------------------------------------------------------------
// trq_req_if
// Request channel of the timed reply queue: queue and poll beats.
// ----------------------------------------------------------------------------
interface trq_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         module_id;
    logic [3:0]         reply_kind_in;
    logic signed [31:0] argument_in;
    logic [31:0]        due_time;
    logic [31:0]        now_time;

    modport source (
        output valid, opcode, module_id, reply_kind_in, argument_in, due_time, now_time,
        input  ready
    );
    modport sink (
        input  valid, opcode, module_id, reply_kind_in, argument_in, due_time, now_time,
        output ready
    );
endinterface

// ===== design/trq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// trq_rsp_if
// Response channel of the timed reply queue: one beat per request beat.
// ----------------------------------------------------------------------------
interface trq_rsp_if;
    logic               valid;
    logic               ready;
    logic               insert_accepted;
    logic               reply_valid;
    logic [7:0]         reply_module;
    logic [3:0]         reply_kind_out;
    logic signed [31:0] reply_argument;
    logic [31:0]        drop_count;

    modport source (
        output valid, insert_accepted, reply_valid, reply_module, reply_kind_out,
               reply_argument, drop_count,
        input  ready
    );
    modport sink (
        input  valid, insert_accepted, reply_valid, reply_module, reply_kind_out,
               reply_argument, drop_count,
        output ready
    );
endinterface

// ===== design/timed_reply_queue_top.sv =====
// ----------------------------------------------------------------------------
// timed_reply_queue_top
// Slot table of pending replies, served earliest due first.
// ----------------------------------------------------------------------------
// Each request beat walks a row of QUEUE_DEPTH slot cells, one cell per clock:
// a queue beat lands in the first free slot, a poll beat collects the earliest
// due used slot (lower slot wins ties), which is freed as the record leaves
// the row. A request walks the row of slot cells, then moves into the result
// stage and then into the output register, which drives the response. The
// next request is taken as soon as the result reaches the output register,
// even if the sink has not yet taken it; while the sink still holds off the
// previous result, the new result waits in the result stage and the input
// stalls until the output register frees up.
// bus_enabled low makes polls return no reply.
module timed_reply_queue_top
    import trq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    trq_req_if.sink   req,
    trq_rsp_if.source rsp,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    trq_rec_t               rec_chain [0:QUEUE_DEPTH];
    logic [IDX_W-1:0]       idx_chain [0:QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] chain_valid;

    trq_rec_t    rec_head;
    logic        bus_enabled_reg;
    logic        busy_reg;
    logic [31:0] dropped_total_reg;
    logic [31:0] dropped_total_next;
    logic        accept;
    logic        clr_en;
    trq_rec_t    last;
    logic        drop;
    logic        transfer;

    logic        pend_valid_reg;
    logic        pend_accepted_reg;
    logic        pend_reply_reg;
    logic [7:0]  pend_module_reg;
    logic [3:0]  pend_kind_reg;
    logic [31:0] pend_argument_reg;
    logic [31:0] pend_drop_reg;

    logic        out_valid_reg;
    logic        out_accepted_reg;
    logic        out_reply_reg;
    logic [7:0]  out_module_reg;
    logic [3:0]  out_kind_reg;
    logic [31:0] out_argument_reg;
    logic [31:0] out_drop_reg;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;

    always_comb
    begin
        rec_head           = '0;
        rec_head.valid     = accept;
        rec_head.op        = req.opcode ? (bus_enabled_reg ? REC_POLL : REC_IDLE)
                                        : REC_INSERT;
        rec_head.time_val  = req.opcode ? req.now_time : req.due_time;
        rec_head.module_id = req.module_id;
        rec_head.kind_code = req.reply_kind_in;
        rec_head.argument  = req.argument_in;
    end
    assign rec_chain[0] = rec_head;
    assign idx_chain[0] = '0;

    assign last   = rec_chain[QUEUE_DEPTH];
    assign clr_en = last.valid && (last.op == REC_POLL) && last.hit;
    assign drop   = last.valid && (last.op == REC_INSERT) && !last.hit;

    generate
        for (genvar g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            trq_cell #(
                .IDX_W (IDX_W),
                .SLOT  (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .rec_in  (rec_chain[g]),
                .idx_in  (idx_chain[g]),
                .rec_out (rec_chain[g+1]),
                .idx_out (idx_chain[g+1]),
                .clr_en  (clr_en),
                .clr_idx (idx_chain[QUEUE_DEPTH])
            );
            assign chain_valid[g] = rec_chain[g+1].valid;
        end
    endgenerate

    always_comb
    begin
        dropped_total_next = dropped_total_reg;
        if (drop && (dropped_total_reg != 32'hFFFF_FFFF))
        begin
            dropped_total_next = dropped_total_reg + 32'd1;
        end
    end

    assign transfer = pend_valid_reg && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_enabled_reg   <= 1'b1;
            busy_reg          <= 1'b0;
            dropped_total_reg <= '0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bus_enabled_reg <= cfg_wdata;
            end
            dropped_total_reg <= dropped_total_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (transfer)
            begin
                busy_reg <= 1'b0;
            end
            if (last.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (transfer)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (transfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; reply fields are zero unless a poll found a slot
    always_ff @(posedge clk)
    begin
        if (last.valid)
        begin
            pend_accepted_reg <= (last.op == REC_INSERT) && last.hit;
            pend_reply_reg    <= clr_en;
            pend_module_reg   <= clr_en ? last.module_id : 8'd0;
            pend_kind_reg     <= clr_en ? last.kind_code : 4'd0;
            pend_argument_reg <= clr_en ? last.argument : 32'd0;
            pend_drop_reg     <= dropped_total_next;
        end
        if (transfer)
        begin
            out_accepted_reg <= pend_accepted_reg;
            out_reply_reg    <= pend_reply_reg;
            out_module_reg   <= pend_module_reg;
            out_kind_reg     <= pend_kind_reg;
            out_argument_reg <= pend_argument_reg;
            out_drop_reg     <= pend_drop_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.insert_accepted = out_accepted_reg;
    assign rsp.reply_valid     = out_reply_reg;
    assign rsp.reply_module    = out_module_reg;
    assign rsp.reply_kind_out  = out_kind_reg;
    assign rsp.reply_argument  = out_argument_reg;
    assign rsp.drop_count      = out_drop_reg;

`ifndef SYNTHESIS
    // at most one record walks the row
    a_single_record: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) <= 1)
        else $error("more than one record in the slot row");

    a_record_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid != '0) |-> busy_reg)
        else $error("record in the slot row while not busy");

    a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (dropped_total_reg >= $past(dropped_total_reg)))
        else $error("drop counter went down");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !(pend_accepted_reg && pend_reply_reg))
        else $error("beat both stored and replied");
`endif

endmodule

// ===== design/trq_cell.sv =====
// ----------------------------------------------------------------------------
// trq_cell
// One reply slot. Takes the scan record from its left neighbour, stores an
// insert if it is the first free slot, or offers itself as the earliest due
// reply of a poll, and registers the record for its right neighbour.
// ----------------------------------------------------------------------------
module trq_cell
    import trq_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int SLOT  = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  trq_rec_t         rec_in,
    input  logic [IDX_W-1:0] idx_in,
    output trq_rec_t         rec_out,
    output logic [IDX_W-1:0] idx_out,
    input  logic             clr_en,
    input  logic [IDX_W-1:0] clr_idx
);

    localparam logic [IDX_W-1:0] SLOT_IDX = IDX_W'(SLOT);

    logic             used_reg;
    logic [31:0]      due_reg;
    logic [7:0]       module_reg;
    logic [3:0]       kind_reg;
    logic [31:0]      argument_reg;
    trq_rec_t         rec_out_reg;
    trq_rec_t         rec_out_next;
    logic [IDX_W-1:0] idx_out_reg;
    logic [IDX_W-1:0] idx_out_next;
    logic             wr_en;
    logic [31:0]      due_diff;
    logic [31:0]      order_diff;

    // wrap-aware compares: sign bit of the 32-bit difference
    assign due_diff   = rec_in.time_val - due_reg;
    assign order_diff = due_reg - rec_in.best_due;

    always_comb
    begin
        rec_out_next = rec_in;
        idx_out_next = idx_in;
        wr_en        = 1'b0;
        if (rec_in.valid)
        begin
            case (rec_in.op)
                REC_INSERT:
                begin
                    if (!rec_in.hit && !used_reg)
                    begin
                        wr_en            = 1'b1;
                        rec_out_next.hit = 1'b1;
                        idx_out_next     = SLOT_IDX;
                    end
                end
                REC_POLL:
                begin
                    if (used_reg && !due_diff[31] && (!rec_in.hit || order_diff[31]))
                    begin
                        rec_out_next.hit       = 1'b1;
                        rec_out_next.best_due  = due_reg;
                        rec_out_next.module_id = module_reg;
                        rec_out_next.kind_code = kind_reg;
                        rec_out_next.argument  = argument_reg;
                        idx_out_next           = SLOT_IDX;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            rec_out_reg <= '0;
        end
        else
        begin
            rec_out_reg <= rec_out_next;
            if (wr_en)
            begin
                used_reg <= 1'b1;
            end
            else if (clr_en && (clr_idx == SLOT_IDX))
            begin
                used_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_out_reg <= idx_out_next;
        if (wr_en)
        begin
            due_reg      <= rec_in.time_val;
            module_reg   <= rec_in.module_id;
            kind_reg     <= rec_in.kind_code;
            argument_reg <= rec_in.argument;
        end
    end

    assign rec_out = rec_out_reg;
    assign idx_out = idx_out_reg;

endmodule

// ===== tb/timed_reply_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// timed_reply_queue_top_test
// Self-checking bench for the timed reply queue. Request beats are driven
// through the request interface and mirrored in a slot-table predictor; every
// response beat is checked field by field against the oldest prediction.
// Covers extremes, wrap-aware due times, ties, a full table with drops, the
// bus enable switch, a long response hold-off and random timed traffic.
// ----------------------------------------------------------------------------
module timed_reply_queue_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import trq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam logic OP_QUEUE  = 1'b0;
    localparam logic OP_POLL   = 1'b1;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         module_id;
        logic [3:0]         kind;
        logic signed [31:0] argument;
        logic [31:0]        due;
        logic [31:0]        now;
    } request_t;

    typedef struct packed {
        logic               stored;
        logic               found;
        logic [7:0]         module_id;
        logic [3:0]         kind;
        logic signed [31:0] argument;
        logic [31:0]        drops;
    } reply_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    trq_req_if req_ch ();
    trq_rsp_if rsp_ch ();

    timed_reply_queue_top #(
        .QUEUE_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic               slot_busy [DEPTH];
    logic [31:0]        slot_due_time [DEPTH];
    logic [7:0]         slot_module_id [DEPTH];
    logic [3:0]         slot_kind_code [DEPTH];
    logic signed [31:0] slot_arg [DEPTH];
    logic [31:0]        dropped_replies;
    logic               bus_on;

    reply_beat_t expected_replies [$];
    int          error_count;
    int          quiet_cycles;
    int          stall_hold;
    bit          quiet_mode;
    logic [31:0] traffic_clock;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic reply_beat_t predict_reply(request_t rq);
        reply_beat_t r;
        int          best;
        logic [31:0] to_now;
        logic [31:0] lead;
        r    = '0;
        best = -1;
        if (rq.opcode == OP_QUEUE)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!r.stored && !slot_busy[i])
                begin
                    slot_busy[i]      = 1'b1;
                    slot_due_time[i]  = rq.due;
                    slot_module_id[i] = rq.module_id;
                    slot_kind_code[i] = rq.kind;
                    slot_arg[i]       = rq.argument;
                    r.stored          = 1'b1;
                end
            end
            if (!r.stored && dropped_replies != 32'hFFFF_FFFF)
                dropped_replies++;
        end
        else if (bus_on)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                to_now = rq.now - slot_due_time[i];
                if (slot_busy[i] && !to_now[31])
                begin
                    if (best < 0)
                        best = i;
                    else
                    begin
                        lead = slot_due_time[i] - slot_due_time[best];
                        if (lead[31])
                            best = i;
                    end
                end
            end
            if (best >= 0)
            begin
                r.found         = 1'b1;
                r.module_id     = slot_module_id[best];
                r.kind          = slot_kind_code[best];
                r.argument      = slot_arg[best];
                slot_busy[best] = 1'b0;
            end
        end
        r.drops = dropped_replies;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    function automatic request_t queue_item(logic [7:0] m, logic [3:0] k,
                                            logic [31:0] a, logic [31:0] d);
        request_t rq;
        rq.opcode    = OP_QUEUE;
        rq.module_id = m;
        rq.kind      = k;
        rq.argument  = a;
        rq.due       = d;
        rq.now       = $urandom;
        return rq;
    endfunction

    function automatic request_t poll_item(logic [31:0] t);
        request_t rq;
        rq.opcode    = OP_POLL;
        rq.module_id = 8'($urandom);
        rq.kind      = 4'($urandom);
        rq.argument  = $urandom;
        rq.due       = $urandom;
        rq.now       = t;
        return rq;
    endfunction

    // timed traffic: due times cluster just ahead of a running clock
    function automatic request_t timed_item(int queue_pct);
        request_t rq;
        int       r;
        traffic_clock = traffic_clock + $urandom_range(0, 20);
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < queue_pct)
        begin
            if (r < 85)
                rq = queue_item(8'($urandom), 4'($urandom), $urandom,
                                traffic_clock + $urandom_range(0, 120));
            else if (r < 93)
                rq = queue_item(8'($urandom), 4'($urandom), $urandom,
                                traffic_clock - $urandom_range(0, 50));
            else
                rq = queue_item(8'($urandom), 4'($urandom), $urandom, $urandom);
        end
        else
        begin
            if (r < 90)
                rq = poll_item(traffic_clock);
            else
                rq = poll_item($urandom);
        end
        return rq;
    endfunction

    task automatic send_beat(request_t rq);
        int gap;
        gap = quiet_mode ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= rq.opcode;
        req_ch.module_id     <= rq.module_id;
        req_ch.reply_kind_in <= rq.kind;
        req_ch.argument_in   <= rq.argument;
        req_ch.due_time      <= rq.due;
        req_ch.now_time      <= rq.now;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_replies.push_back(predict_reply(rq));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bus_enable(logic v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bus_on = v;
    endtask

    task automatic test_directed_cases();
        send_beat(poll_item(32'h0000_0000));
        send_beat(queue_item(8'hFF, 4'hF, 32'h7FFF_FFFF, 32'hFFFF_FFF0));
        send_beat(queue_item(8'h00, 4'h0, 32'h8000_0000, 32'd5));
        send_beat(queue_item(8'h5A, 4'hA, 32'h0000_0000, 32'd5));
        // wrapped due time counts as reached
        send_beat(poll_item(32'h0000_0000));
        send_beat(poll_item(32'd4));
        send_beat(poll_item(32'hFFFF_FFFF));
        // equal due times: lower slot first
        send_beat(poll_item(32'd5));
        send_beat(poll_item(32'd100));
        // fill the table, then two drops
        for (int i = 0; i < DEPTH + 2; i++)
            send_beat(queue_item(8'($urandom), 4'($urandom), $urandom,
                                 (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom));
        wait_idle();
    endtask

    task automatic test_bus_disable();
        write_bus_enable(1'b0);
        send_beat(queue_item(8'($urandom), 4'($urandom), $urandom, 32'd10));
        send_beat(poll_item(32'd20));
        send_beat(poll_item(32'hFFFF_FFFF));
        write_bus_enable(1'b1);
        for (int i = 0; i < DEPTH + 1; i++)
            send_beat(poll_item(32'd20));
        wait_idle();
    endtask

    task automatic test_response_hold_off();
        traffic_clock = $urandom;
        stall_hold = 300;
        quiet_mode = 1'b1;
        for (int i = 0; i < 12; i++)
            send_beat(timed_item(60));
        quiet_mode = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int queue_share [6];
        queue_share = '{50, 70, 35, 55, 60, 45};
        for (int p = 0; p < 6; p++)
        begin
            write_bus_enable((p == 1 || p == 4) ? 1'b0 : 1'b1);
            traffic_clock = (p == 2) ? 32'hFFFF_FF00 : $urandom;
            quiet_mode = (p == 3);
            for (int i = 0; i < 150; i++)
                send_beat(timed_item(queue_share[p]));
            quiet_mode = 1'b0;
        end
        wait_idle();
    endtask

    // response sink with random hold-offs
    initial begin
        int span;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_hold > 0)
            begin
                span = stall_hold;
                stall_hold = 0;
                rsp_ch.ready <= 1'b0;
            end
            else if (quiet_mode)
            begin
                span = 1;
                rsp_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                span = $urandom_range(1, 10);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                span = 1 + idle_gap();
                rsp_ch.ready <= 1'b0;
            end
            repeat (span) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        reply_beat_t got;
        reply_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.stored    = rsp_ch.insert_accepted;
            got.found     = rsp_ch.reply_valid;
            got.module_id = rsp_ch.reply_module;
            got.kind      = rsp_ch.reply_kind_out;
            got.argument  = rsp_ch.reply_argument;
            got.drops     = rsp_ch.drop_count;
            if (expected_replies.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("%0t: response beat with nothing expected", $realtime);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("%0t: mismatch exp acc=%b rv=%b mod=%h kind=%h arg=%h drops=%0d",
                                 $realtime, want.stored, want.found, want.module_id,
                                 want.kind, want.argument, want.drops,
                                 "\n           got acc=%b rv=%b mod=%h kind=%h arg=%h drops=%0d",
                                 got.stored, got.found, got.module_id, got.kind,
                                 got.argument, got.drops);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timed_reply_queue_top_test NOT OK");
            $finish;
        end
    end

    initial begin
        error_count     = 0;
        quiet_cycles    = 0;
        stall_hold      = 0;
        quiet_mode      = 1'b0;
        traffic_clock   = '0;
        dropped_replies = '0;
        bus_on          = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_busy[i]      = 1'b0;
            slot_due_time[i]  = '0;
            slot_module_id[i] = '0;
            slot_kind_code[i] = '0;
            slot_arg[i]       = '0;
        end
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_QUEUE;
        req_ch.module_id     <= '0;
        req_ch.reply_kind_in <= '0;
        req_ch.argument_in   <= '0;
        req_ch.due_time      <= '0;
        req_ch.now_time      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_bus_disable();
        test_response_hold_off();
        test_random_traffic();

        wait_idle();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("timed_reply_queue_top_test OK");
        else
            $display("timed_reply_queue_top_test NOT OK");
        $finish;
    end

endmodule
